### rtl/ttms_pkg.sv
// Shared types and constants for the sorted tag table.
package ttms_pkg;

  localparam int TABLE_DEPTH   = 32;
  localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int RANK_W        = 5;
  localparam int CMP_W         = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int ID_W          = 96;
  localparam int BEST_W        = 8;
  localparam int COUNT_W       = 6;
  localparam int ENTRY_W       = ID_W + BEST_W;
  localparam logic [7:0] QUIET_ANTENNA = 8'd2;

  typedef enum logic [1:0] {
    K_SIGHT = 2'd0,
    K_QUIET = 2'd1,
    K_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_UPDATED    = 3'd0,
    ST_INSERTED   = 3'd1,
    ST_DROPPED    = 3'd2,
    ST_OTHER_ANT  = 3'd3,
    ST_READ_OK    = 3'd4,
    ST_READ_EMPTY = 3'd5
  } status_t;

  typedef struct packed {
    kind_t                    kind;
    logic [ID_W-1:0]          id;
    logic signed [BEST_W-1:0] strength;
    logic [RANK_W-1:0]        rank;
  } op_t;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [BEST_W-1:0] best;
  } entry_t;

  typedef struct packed {
    status_t                  status;
    logic [RANK_W-1:0]        rank;
    logic signed [BEST_W-1:0] best;
    logic [ID_W-1:0]          id;
  } res_t;

  typedef struct packed {
    res_t                 res;
    logic [COUNT_W-1:0]   count;
  } out_t;

endpackage

### rtl/tag_table_max_rssi_sorted.sv
// Sorted tag table top level: a table of up to 32 tag identifiers, each with
// its highest strength seen, kept in descending order of that strength with
// ties in the order the entries reached that strength. Inputs pass through a
// two-entry queue, so the input side keeps taking transfers until the queue is
// full while the table sequencer works and while a result waits on the output.
// The table sits in one RAM with a single read and a single write port, and
// the sequencer visits the entries one at a time. A sighting searches the
// table from rank 0 and then bubbles its entry up; a new tag on a full table
// is dropped. No clearing pass is needed after reset; only ranks below the
// entry count are ever read.
module tag_table_max_rssi_sorted (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // antenna[7:0], tag_id_high[39:8], tag_id_low[103:40], strength[111:104],
  // read_rank[116:112], zero fill above
  input  logic [119:0]  in_tdata,
  // cmd[0]
  input  logic          in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // rank[4:0], best_strength[12:5], out_id_high[44:13], out_id_low[108:45],
  // entry_count[114:109], zero fill above
  output logic [119:0]  out_tdata,
  // status[2:0]
  output logic [2:0]    out_tuser
);
  import ttms_pkg::*;

  logic   q_valid, q_ready;
  op_t    q_item;
  out_t   out_data;

  ttms_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_cmd      (in_tuser),
    .in_antenna  (in_tdata[7:0]),
    .in_id       ({in_tdata[39:8], in_tdata[103:40]}),
    .in_strength ($signed(in_tdata[111:104])),
    .in_rank     (in_tdata[116:112]),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item)
  );

  ttms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tuser = out_data.res.status;
  assign out_tdata = {5'd0,
                      out_data.count,
                      out_data.res.id[63:0],
                      out_data.res.id[95:64],
                      out_data.res.best,
                      out_data.res.rank};

endmodule

### rtl/ttms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ttms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/ttms_front.sv
// Input side: classify each transfer and hold it in a two-entry queue.
module ttms_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [7:0]        in_antenna,
  input  logic [ttms_pkg::ID_W-1:0]   in_id,
  input  logic signed [ttms_pkg::BEST_W-1:0] in_strength,
  input  logic [ttms_pkg::RANK_W-1:0] in_rank,
  output logic              q_valid,
  input  logic              q_ready,
  output ttms_pkg::op_t     q_item
);
  import ttms_pkg::*;

  op_t        q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  op_t        op_in;
  logic       push, pop;

  always_comb begin
    op_in.id       = in_id;
    op_in.strength = in_strength;
    op_in.rank     = in_rank;
    priority if (in_cmd) begin
      op_in.kind = K_READ;
    end else if (in_antenna == QUIET_ANTENNA) begin
      op_in.kind = K_QUIET;
    end else begin
      op_in.kind = K_SIGHT;
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

### rtl/ttms_back.sv
// Table sequencer: search, insert, bubble up, read, and the result register.
module ttms_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  ttms_pkg::op_t  q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output ttms_pkg::out_t out_data
);
  import ttms_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RDWAIT = 7'b0000010,
    S_SEARCH = 7'b0000100,
    S_NEW    = 7'b0001000,
    S_BUBBLE = 7'b0010000,
    S_PLACE  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  entry_t           mov_r, mov_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  res_t             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, rd;

  ttms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    mov_nxt       = mov_r;
    fill_nxt      = fill_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    q_ready       = 1'b0;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = mov_r;
    raddr         = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_ready = 1'b1;
          op_nxt  = q_item;
          unique case (q_item.kind)
            K_READ: begin
              if (CMP_W'(q_item.rank) < CMP_W'(fill_r)) begin
                raddr     = IDX_W'(q_item.rank);
                state_nxt = S_RDWAIT;
              end else begin
                res_nxt.status = ST_READ_EMPTY;
                res_nxt.rank   = q_item.rank;
                res_nxt.best   = '0;
                res_nxt.id     = '0;
                state_nxt      = S_FINISH;
              end
            end
            K_QUIET: begin
              res_nxt.status = ST_OTHER_ANT;
              res_nxt.rank   = '0;
              res_nxt.best   = '0;
              res_nxt.id     = q_item.id;
              state_nxt      = S_FINISH;
            end
            K_SIGHT: begin
              if (fill_r == '0) begin
                state_nxt = S_NEW;
              end else begin
                raddr     = '0;
                idx_nxt   = '0;
                state_nxt = S_SEARCH;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        res_nxt.status = ST_READ_OK;
        res_nxt.rank   = op_r.rank;
        res_nxt.best   = rd.best;
        res_nxt.id     = rd.id;
        state_nxt      = S_FINISH;
      end
      S_SEARCH: begin
        priority if (rd.id == op_r.id) begin
          mov_nxt.id     = rd.id;
          mov_nxt.best   = (op_r.strength > rd.best) ? op_r.strength : rd.best;
          pos_nxt        = idx_r;
          res_nxt.status = ST_UPDATED;
          if (idx_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            raddr     = idx_r - IDX_W'(1);
            state_nxt = S_BUBBLE;
          end
        end else if ((CNT_W'(idx_r) + CNT_W'(1)) < fill_r) begin
          raddr   = idx_r + IDX_W'(1);
          idx_nxt = idx_r + IDX_W'(1);
        end else begin
          state_nxt = S_NEW;
        end
      end
      S_NEW: begin
        if (fill_r < CNT_W'(TABLE_DEPTH)) begin
          mov_nxt.id     = op_r.id;
          mov_nxt.best   = op_r.strength;
          pos_nxt        = IDX_W'(fill_r);
          fill_nxt       = fill_r + CNT_W'(1);
          res_nxt.status = ST_INSERTED;
          if (fill_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            raddr     = IDX_W'(fill_r) - IDX_W'(1);
            state_nxt = S_BUBBLE;
          end
        end else begin
          res_nxt.status = ST_DROPPED;
          res_nxt.rank   = '0;
          res_nxt.best   = '0;
          res_nxt.id     = op_r.id;
          state_nxt      = S_FINISH;
        end
      end
      S_BUBBLE: begin
        if (rd.best < mov_r.best) begin
          we      = 1'b1;
          waddr   = pos_r;
          wdata   = rd;
          pos_nxt = pos_r - IDX_W'(1);
          if (pos_r == IDX_W'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            raddr = pos_r - IDX_W'(2);
          end
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        we           = 1'b1;
        waddr        = pos_r;
        wdata        = mov_r;
        res_nxt.rank = RANK_W'(pos_r);
        res_nxt.best = mov_r.best;
        res_nxt.id   = mov_r.id;
        state_nxt    = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.res   = res_r;
          out_nxt.count = COUNT_W'(fill_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    mov_r <= mov_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### tb/sv/tag_table_max_rssi_sorted_tb.sv
// Self-checking testbench for the sorted tag table: directed and random traffic.
`timescale 1ns / 1ps

module tag_table_max_rssi_sorted_tb;
  import ttms_pkg::*;

  typedef struct {
    logic                     cmd;
    logic [7:0]               antenna;
    logic [ID_W-1:0]          id;
    logic signed [BEST_W-1:0] strength;
    logic [RANK_W-1:0]        read_rank;
  } sight_t;

  typedef struct {
    status_t                  status;
    logic [RANK_W-1:0]        rank;
    logic signed [BEST_W-1:0] best;
    logic [ID_W-1:0]          id;
    logic [COUNT_W-1:0]       count;
  } tag_report_t;

  localparam int POOL_SIZE = 48;
  localparam int HOLD_CYCLES = 300;
  localparam logic [ID_W-1:0] ID_ZERO = '0;
  localparam logic [ID_W-1:0] ID_ONES = '1;
  localparam logic [ID_W-1:0] ID_ALT_A = {24{4'hA}};
  localparam logic [ID_W-1:0] ID_ALT_5 = {24{4'h5}};

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic [2:0]   out_tuser;

  sight_t      sight_queue[$];
  tag_report_t report_queue[$];
  sight_t      drv_item;
  logic [ID_W-1:0] tag_pool [POOL_SIZE];

  logic [ID_W-1:0]          tbl_id   [TABLE_DEPTH];
  logic signed [BEST_W-1:0] tbl_best [TABLE_DEPTH];
  int tbl_fill = 0;

  int tx_max_gap = 18;
  int rx_max_gap = 18;
  int tx_wait = 0;
  int rx_wait = 0;
  int hold_asks = 0;
  int hold_done = 0;
  int hold_left = 0;
  int accepted = 0;
  int checked = 0;
  int errors = 0;
  int status_seen [6];

  tag_table_max_rssi_sorted u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int rise_entry(int pos);
    logic [ID_W-1:0]          hold_id;
    logic signed [BEST_W-1:0] hold_best;
    while (pos > 0 && tbl_best[pos-1] < tbl_best[pos]) begin
      hold_id = tbl_id[pos-1];
      hold_best = tbl_best[pos-1];
      tbl_id[pos-1] = tbl_id[pos];
      tbl_best[pos-1] = tbl_best[pos];
      tbl_id[pos] = hold_id;
      tbl_best[pos] = hold_best;
      pos--;
    end
    return pos;
  endfunction

  function automatic tag_report_t table_apply(sight_t s);
    tag_report_t r;
    int hit;
    int pos;
    r.status = ST_DROPPED;
    r.rank = '0;
    r.best = '0;
    r.id = s.id;
    hit = -1;
    if (s.cmd) begin
      r.rank = s.read_rank;
      if (s.read_rank < tbl_fill) begin
        r.status = ST_READ_OK;
        r.best = tbl_best[s.read_rank];
        r.id = tbl_id[s.read_rank];
      end else begin
        r.status = ST_READ_EMPTY;
        r.id = '0;
      end
    end else if (s.antenna == QUIET_ANTENNA) begin
      r.status = ST_OTHER_ANT;
    end else begin
      for (int i = 0; i < tbl_fill; i++)
        if (hit < 0 && tbl_id[i] == s.id) hit = i;
      if (hit >= 0) begin
        if (s.strength > tbl_best[hit]) tbl_best[hit] = s.strength;
        pos = rise_entry(hit);
        r.status = ST_UPDATED;
      end else if (tbl_fill < TABLE_DEPTH) begin
        tbl_id[tbl_fill] = s.id;
        tbl_best[tbl_fill] = s.strength;
        tbl_fill++;
        pos = rise_entry(tbl_fill - 1);
        r.status = ST_INSERTED;
      end
      if (r.status != ST_DROPPED) begin
        r.rank = pos[RANK_W-1:0];
        r.best = tbl_best[pos];
        r.id = tbl_id[pos];
      end
    end
    r.count = tbl_fill[COUNT_W-1:0];
    return r;
  endfunction

  function automatic sight_t mk_sight(logic cmd, logic [7:0] antenna, logic [ID_W-1:0] id,
                                      int strength, int read_rank);
    sight_t s;
    s.cmd = cmd;
    s.antenna = antenna;
    s.id = id;
    s.strength = strength[BEST_W-1:0];
    s.read_rank = read_rank[RANK_W-1:0];
    return s;
  endfunction

  function automatic sight_t rand_sight();
    sight_t s;
    int pick;
    pick = $urandom_range(0, 99);
    s.cmd = 1'b0;
    s.antenna = 8'($urandom);
    s.id = {$urandom, $urandom, $urandom};
    s.strength = BEST_W'($urandom);
    s.read_rank = RANK_W'($urandom);
    if (pick < 25) begin
      s.cmd = 1'b1;
    end else if (pick < 33) begin
      s.antenna = QUIET_ANTENNA;
      s.id = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (pick >= 43) begin
      s.id = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (s.antenna == QUIET_ANTENNA) s.antenna = 8'd3;
    end
    return s;
  endfunction

  task automatic drain();
    while (sight_queue.size() != 0 || in_tvalid || report_queue.size() != 0)
      @(posedge clk);
  endtask

  // sender: one transfer per item, random gap after each
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        report_queue.push_back(table_apply(drv_item));
        accepted++;
        tx_wait = $urandom_range(0, tx_max_gap);
      end
      if (!in_tvalid || in_tready) begin
        if (tx_wait == 0 && sight_queue.size() != 0) begin
          drv_item = sight_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= drv_item.cmd;
          in_tdata <= {3'b000, drv_item.read_rank, drv_item.strength, drv_item.id[63:0],
                       drv_item.id[95:64], drv_item.antenna};
        end else begin
          in_tvalid <= 1'b0;
          if (tx_wait > 0) tx_wait--;
        end
      end
    end
  end

  // receiver: random stall after each transfer, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_asks != hold_done) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (out_tready && out_tvalid) begin
      rx_wait = $urandom_range(0, rx_max_gap);
      out_tready <= (rx_wait == 0);
    end else if (!out_tready) begin
      if (rx_wait > 0) rx_wait--;
      else out_tready <= 1'b1;
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    tag_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (report_queue.size() == 0) begin
        $error("result transfer with no prediction pending: tuser %0d tdata %h",
               out_tuser, out_tdata);
        errors++;
      end else begin
        want = report_queue.pop_front();
        checked++;
        status_seen[int'(want.status)]++;
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          errors++;
        end
        if (out_tdata[4:0] !== want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, out_tdata[4:0]);
          errors++;
        end
        if (out_tdata[12:5] !== want.best) begin
          $error("best_strength: expected %0d, got %0d", want.best,
                 $signed(out_tdata[12:5]));
          errors++;
        end
        if (out_tdata[44:13] !== want.id[95:64]) begin
          $error("out_id_high: expected %h, got %h", want.id[95:64], out_tdata[44:13]);
          errors++;
        end
        if (out_tdata[108:45] !== want.id[63:0]) begin
          $error("out_id_low: expected %h, got %h", want.id[63:0], out_tdata[108:45]);
          errors++;
        end
        if (out_tdata[114:109] !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, out_tdata[114:109]);
          errors++;
        end
      end
    end
  end

  initial begin
    tag_pool[0] = ID_ZERO;
    tag_pool[1] = ID_ONES;
    tag_pool[2] = ID_ALT_A;
    tag_pool[3] = ID_ALT_5;
    for (int i = 4; i < POOL_SIZE; i++) tag_pool[i] = {$urandom, $urandom, $urandom};
    for (int i = 0; i < 6; i++) status_seen[i] = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    sight_queue.push_back(mk_sight(1'b1, 8'h00, ID_ZERO, 0, 0));
    sight_queue.push_back(mk_sight(1'b1, 8'hFF, ID_ONES, -1, 31));
    sight_queue.push_back(mk_sight(1'b0, QUIET_ANTENNA, ID_ONES, 127, 31));
    sight_queue.push_back(mk_sight(1'b0, 8'd0, ID_ZERO, -128, 0));
    sight_queue.push_back(mk_sight(1'b0, 8'd255, ID_ONES, 127, 0));
    sight_queue.push_back(mk_sight(1'b0, 8'd1, ID_ALT_A, -128, 0));
    sight_queue.push_back(mk_sight(1'b0, 8'd3, ID_ZERO, 5, 0));
    sight_queue.push_back(mk_sight(1'b0, 8'd3, ID_ZERO, -3, 0));
    sight_queue.push_back(mk_sight(1'b0, 8'd1, ID_ALT_5, 5, 0));
    sight_queue.push_back(mk_sight(1'b0, QUIET_ANTENNA, ID_ZERO, 127, 0));
    sight_queue.push_back(mk_sight(1'b0, 8'd4, ID_ALT_A, 127, 0));
    sight_queue.push_back(mk_sight(1'b0, 8'd7, ID_ONES, -128, 0));
    sight_queue.push_back(mk_sight(1'b0, 8'd170, ID_ALT_5, 126, 0));
    for (int i = 0; i < 5; i++)
      sight_queue.push_back(mk_sight(1'b1, 8'($urandom), {$urandom, $urandom, $urandom},
                                     $urandom, i));
    sight_queue.push_back(mk_sight(1'b1, 8'd2, ID_ONES, 127, 31));
    sight_queue.push_back(mk_sight(1'b1, 8'd85, ID_ALT_5, -128, 16));
    drain();

    // stall the result side while the sender keeps offering back to back
    tx_max_gap = 0;
    hold_asks++;
    for (int i = 0; i < 40; i++) sight_queue.push_back(rand_sight());
    drain();

    for (int chunk = 0; chunk < 7; chunk++) begin
      case (chunk % 4)
        0: begin tx_max_gap = 18; rx_max_gap = 18; end
        1: begin tx_max_gap = 0;  rx_max_gap = 0;  end
        2: begin tx_max_gap = 0;  rx_max_gap = 18; end
        default: begin tx_max_gap = 18; rx_max_gap = 0; end
      endcase
      for (int i = 0; i < 100; i++) sight_queue.push_back(rand_sight());
      while (sight_queue.size() > 4) @(posedge clk);
    end

    drain();
    repeat (100) @(posedge clk);

    $display("Checked %0d of %0d transfers: %0d updates, %0d inserts, %0d drops, %0d antenna two",
             checked, accepted, status_seen[ST_UPDATED], status_seen[ST_INSERTED],
             status_seen[ST_DROPPED], status_seen[ST_OTHER_ANT]);
    $display("Reads: %0d within the fill, %0d past it; table ended with %0d of %0d entries",
             status_seen[ST_READ_OK], status_seen[ST_READ_EMPTY], tbl_fill, TABLE_DEPTH);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
